[rtl/tma_pkg.sv]
// ----------------------------------------------------------------------------
// tma_pkg
// Shared types, widths and constants of the thermocouple moving average.
// ----------------------------------------------------------------------------
package tma_pkg;

    localparam int MAX_WINDOW = 16;
    localparam int LEN_W      = 5;
    localparam int POS_W      = 4;
    localparam int COUNT_W    = 13;
    localparam int SUM_W      = 17;
    localparam int DIV_W      = 22;
    localparam int DIV_CNT_W  = 5;
    localparam int C_W        = 18;
    localparam int F_W        = 19;

    localparam logic [LEN_W-1:0] DEFAULT_LEN   = 5'd5;
    localparam logic [LEN_W-1:0] MAX_LEN       = 5'd16;
    localparam logic [LEN_W-1:0] F_DIVISOR     = 5'd5;
    localparam logic [F_W-1:0]   F_OFFSET      = 19'd3200;
    localparam logic [C_W-1:0]   K_OFFSET      = 18'd27315;
    localparam int               FAULT_BIT     = 2;
    localparam logic             REG_WIN_LEN   = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMMIT,
        S_DIVC,
        S_DIVC_WAIT,
        S_DIVF,
        S_DIVF_WAIT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic clear;
        logic lookup;
        logic commit;
    } t_win_ctl;

    // sum * 25 as shift-add
    function automatic logic [DIV_W-1:0] mul25(input logic [SUM_W-1:0] v);
        logic [DIV_W-1:0] x;
        x = {{(DIV_W-SUM_W){1'b0}}, v};
        return (x << 4) + (x << 3) + x;
    endfunction

    // c * 9 as shift-add
    function automatic logic [DIV_W-1:0] mul9(input logic [C_W-1:0] v);
        logic [DIV_W-1:0] x;
        x = {{(DIV_W-C_W){1'b0}}, v};
        return (x << 3) + x;
    endfunction

endpackage

[rtl/tma_window.sv]
// ----------------------------------------------------------------------------
// tma_window
// Sliding window store of quarter-degree counts with running sum.
// ----------------------------------------------------------------------------
module tma_window
    import tma_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_win_ctl           i_ctl,
    input  logic [LEN_W-1:0]   i_len,
    input  logic [COUNT_W-1:0] i_count,
    output logic [SUM_W-1:0]   o_sum,
    output logic               o_full
);

    logic [COUNT_W-1:0] r_store [MAX_WINDOW];
    logic [COUNT_W-1:0] r_old;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   n_pos;
    logic [LEN_W-1:0]   r_fill;
    logic [LEN_W-1:0]   n_fill;
    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W-1:0]   n_sum;
    logic [LEN_W-1:0]   pos_inc;
    logic               at_len;

    always_ff @(posedge i_clk) begin
        if (i_ctl.lookup) begin
            r_old <= r_store[r_pos];
        end
        if (i_ctl.commit) begin
            r_store[r_pos] <= i_count;
        end
    end

    always_comb begin
        at_len  = (r_fill >= i_len);
        pos_inc = {1'b0, r_pos} + 5'd1;
        n_pos   = (pos_inc >= i_len) ? '0 : pos_inc[POS_W-1:0];
        if (at_len) begin
            n_fill = r_fill;
            n_sum  = r_sum - {{(SUM_W-COUNT_W){1'b0}}, r_old}
                   + {{(SUM_W-COUNT_W){1'b0}}, i_count};
        end else begin
            n_fill = r_fill + 5'd1;
            n_sum  = r_sum + {{(SUM_W-COUNT_W){1'b0}}, i_count};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_pos  <= '0;
            r_fill <= '0;
            r_sum  <= '0;
        end else if (i_ctl.commit) begin
            r_pos  <= n_pos;
            r_fill <= n_fill;
            r_sum  <= n_sum;
        end
    end

    assign o_sum  = r_sum;
    assign o_full = (r_fill == i_len);

    a_fill_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= i_len)
        else $error("fill count exceeds window length");

    a_pos_lt_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pos} < i_len)
        else $error("write position outside window");

    a_empty_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill == '0 |-> r_sum == '0 && r_pos == '0)
        else $error("empty window with nonzero sum or position");

endmodule

[rtl/tma_serdiv.sv]
// ----------------------------------------------------------------------------
// tma_serdiv
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tma_serdiv
    import tma_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [LEN_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);

    logic [DIV_W-1:0]     r_sh;
    logic [LEN_W-1:0]     r_rem;
    logic [LEN_W-1:0]     r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [LEN_W:0]       rem_sh;
    logic [LEN_W:0]       rem_sub;
    logic                 q_bit;

    always_comb begin
        rem_sh  = {r_rem, r_sh[DIV_W-1]};
        q_bit   = (rem_sh >= {1'b0, r_div});
        rem_sub = q_bit ? (rem_sh - {1'b0, r_div}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_sh  <= {r_sh[DIV_W-2:0], q_bit};
            r_rem <= rem_sub[LEN_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_sh;

    a_rem_lt_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_busy))
        else $error("divider done without a finished pass");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

endmodule

[rtl/thermocouple_moving_average.sv]
// ----------------------------------------------------------------------------
// thermocouple_moving_average
// Moving average of thermocouple converter frames in C, F and K hundredths.
// ----------------------------------------------------------------------------
// One frame at a time: a beat is taken when the block is idle, and its result
// comes from two 22-step passes of the shared bit-serial divider (sum*25 over
// the window length, then C*9 over 5). A finished result waits in the output
// register while the next frame is already taken. Frames with the open-input
// bit set leave the window untouched and report fault. Writing window_length
// (addresses 0-3; 0 selects 5, above 16 saturates to 16) clears the window;
// the mean reads valid once that many good frames arrived.
// ----------------------------------------------------------------------------
module thermocouple_moving_average
    import tma_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [15:0]       i_raw_frame,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_mean_valid,
    output logic              o_fault,
    output logic [C_W-1:0]    o_celsius_hundredths,
    output logic [F_W-1:0]    o_fahrenheit_hundredths,
    output logic [C_W-1:0]    o_kelvin_hundredths,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_state             r_state;
    t_state             n_state;
    logic [15:0]        r_frame;
    logic [LEN_W-1:0]   r_win_len;
    logic [LEN_W-1:0]   wr_len;
    logic [C_W-1:0]     r_c;
    logic [F_W-1:0]     r_f;
    logic               r_out_valid;
    logic               r_mean_valid;
    logic               r_fault;
    logic [C_W-1:0]     r_out_c;
    logic [F_W-1:0]     r_out_f;
    logic [C_W-1:0]     r_out_k;
    logic               cfg_wr;
    logic               in_take;
    logic               out_load;
    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [LEN_W-1:0]   div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_quot;
    logic [SUM_W-1:0]   win_sum;
    logic               win_full;
    t_win_ctl           win_ctl;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WIN_LEN);
    assign prdata = (paddr[2] == REG_WIN_LEN) ? {27'd0, r_win_len} : 32'd0;

    always_comb begin
        wr_len = pwdata[LEN_W-1:0];
        if (wr_len == '0) begin
            wr_len = DEFAULT_LEN;
        end else if (wr_len > MAX_LEN) begin
            wr_len = MAX_LEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= DEFAULT_LEN;
        end else if (cfg_wr) begin
            r_win_len <= wr_len;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_state        = r_state;
        div_start      = 1'b0;
        div_dividend   = mul25(win_sum);
        div_divisor    = r_win_len;
        out_load       = 1'b0;
        win_ctl.clear  = cfg_wr;
        win_ctl.lookup = in_take;
        win_ctl.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                win_ctl.commit = !r_frame[FAULT_BIT];
                n_state        = S_DIVC;
            end
            S_DIVC: begin
                div_start = 1'b1;
                n_state   = S_DIVC_WAIT;
            end
            S_DIVC_WAIT: begin
                if (div_done) begin
                    n_state = S_DIVF;
                end
            end
            S_DIVF: begin
                div_start    = 1'b1;
                div_dividend = mul9(r_c);
                div_divisor  = F_DIVISOR;
                n_state      = S_DIVF_WAIT;
            end
            S_DIVF_WAIT: begin
                if (div_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_frame <= i_raw_frame;
        end
        if (r_state == S_DIVC_WAIT && div_done) begin
            r_c <= div_quot[C_W-1:0];
        end
        if (r_state == S_DIVF_WAIT && div_done) begin
            r_f <= div_quot[F_W-1:0] + F_OFFSET;
        end
        if (out_load) begin
            r_mean_valid <= win_full;
            r_fault      <= r_frame[FAULT_BIT];
            r_out_c      <= win_full ? r_c : '0;
            r_out_f      <= win_full ? r_f : '0;
            r_out_k      <= win_full ? (r_c + K_OFFSET) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    tma_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (win_ctl),
        .i_len   (r_win_len),
        .i_count (r_frame[15:3]),
        .o_sum   (win_sum),
        .o_full  (win_full)
    );

    tma_serdiv u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    assign o_out_valid             = r_out_valid;
    assign o_mean_valid            = r_mean_valid;
    assign o_fault                 = r_fault;
    assign o_celsius_hundredths    = r_out_c;
    assign o_fahrenheit_hundredths = r_out_f;
    assign o_kelvin_hundredths     = r_out_k;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_mean_valid |->
            r_out_c == '0 && r_out_f == '0 && r_out_k == '0)
        else $error("temperatures nonzero without a full window");

    a_kelvin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_mean_valid |-> r_out_k == r_out_c + K_OFFSET)
        else $error("kelvin does not follow celsius");

    a_f_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_mean_valid |-> r_out_f >= F_OFFSET)
        else $error("fahrenheit below offset");

endmodule

[tb/sv/thermocouple_moving_average_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermocouple_moving_average_checker
// Watches the frame, result and register channels of the moving average.
// Keeps its own copy of the averaging window and the window length. Every
// accepted frame gives one expected mean, and every result beat is compared
// field by field with the oldest one. It hands back the number of means still
// outstanding and the number of mismatches.
// ----------------------------------------------------------------------------
module thermocouple_moving_average_checker
    import tma_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  logic [15:0]    i_raw_frame,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  logic           i_mean_valid,
    input  logic           i_fault,
    input  logic [C_W-1:0] i_celsius_hundredths,
    input  logic [F_W-1:0] i_fahrenheit_hundredths,
    input  logic [C_W-1:0] i_kelvin_hundredths,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    input  logic           pready,
    output int             o_pending,
    output int             o_errors
);

    localparam logic [2:0] WIN_LEN_ADDR = {REG_WIN_LEN, 2'b00};
    localparam int         EXP_DEPTH    = 16;
    localparam int         EXP_IDX_W    = 4;

    typedef struct packed {
        logic           mean_valid;
        logic           fault;
        logic [C_W-1:0] celsius;
        logic [F_W-1:0] fahrenheit;
        logic [C_W-1:0] kelvin;
    } t_mean;

    t_mean              exp_buf [EXP_DEPTH];
    logic [EXP_IDX_W-1:0] exp_wr;
    logic [EXP_IDX_W-1:0] exp_rd;
    int                 exp_count;
    logic [LEN_W-1:0]   win_len;
    logic [COUNT_W-1:0] window_counts [MAX_WINDOW];
    logic [POS_W-1:0]   wr_pos;
    int unsigned        fill;
    int unsigned        count_sum;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic logic [LEN_W-1:0] clamp_length(input logic [LEN_W-1:0] v);
        if (v == '0) begin
            v = DEFAULT_LEN;
        end
        if (v > MAX_LEN) begin
            v = MAX_LEN;
        end
        return v;
    endfunction

    function void clear_window();
        wr_pos    = '0;
        fill      = 0;
        count_sum = 0;
    endfunction

    function automatic t_mean average_frame(input logic [15:0] frame);
        t_mean       r;
        int unsigned c;
        r       = '0;
        r.fault = frame[FAULT_BIT];
        if (!r.fault) begin
            if (fill >= win_len) begin
                count_sum = count_sum - window_counts[wr_pos];
            end else begin
                fill = fill + 1;
            end
            window_counts[wr_pos] = frame[15:3];
            count_sum             = count_sum + frame[15:3];
            if (({1'b0, wr_pos} + 5'd1) >= win_len) begin
                wr_pos = '0;
            end else begin
                wr_pos = wr_pos + 1'b1;
            end
        end
        r.mean_valid = (fill == win_len);
        if (r.mean_valid) begin
            c            = (count_sum * 25) / win_len;
            r.celsius    = C_W'(c);
            r.fahrenheit = F_W'((c * 9) / F_DIVISOR + F_OFFSET);
            r.kelvin     = C_W'(c + K_OFFSET);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_errors++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_mean want;
        if (!i_rst_n) begin
            win_len = clamp_length(DEFAULT_LEN);
            clear_window();
            exp_wr    = '0;
            exp_rd    = '0;
            exp_count = 0;
            o_pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == WIN_LEN_ADDR) begin
                win_len = clamp_length(pwdata[LEN_W-1:0]);
                clear_window();
            end
            if (i_out_valid && !i_out_stall) begin
                if (exp_count == 0) begin
                    report_mismatch("result beat with no mean outstanding");
                end else begin
                    want      = exp_buf[exp_rd];
                    exp_rd    = exp_rd + 1'b1;
                    exp_count = exp_count - 1;
                    check_field("mean_valid", i_mean_valid, want.mean_valid);
                    check_field("fault", i_fault, want.fault);
                    check_field("celsius", i_celsius_hundredths, want.celsius);
                    check_field("fahrenheit", i_fahrenheit_hundredths,
                                want.fahrenheit);
                    check_field("kelvin", i_kelvin_hundredths, want.kelvin);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = average_frame(i_raw_frame);
                if (exp_count == EXP_DEPTH) begin
                    report_mismatch("too many means outstanding");
                end else begin
                    exp_buf[exp_wr] = want;
                    exp_wr          = exp_wr + 1'b1;
                    exp_count       = exp_count + 1;
                end
            end
            o_pending <= exp_count;
        end
    end

endmodule

[tb/sv/thermocouple_moving_average_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermocouple_moving_average_tb
// Stimulus and verdict for the thermocouple moving average.
// A directed run covers count extremes, faulted frames before and after the
// window fills, and the shortest and longest windows. Random frames follow
// in segments, each after a window length write (zero, oversize and in-range
// values), under three back-pressure profiles. Checking lives in the checker.
// ----------------------------------------------------------------------------
module thermocouple_moving_average_tb;
    import tma_pkg::*;

    localparam logic [2:0] WIN_LEN_ADDR = {REG_WIN_LEN, 2'b00};
    localparam int         SEGMENTS     = 7;
    localparam int         SEG_FRAMES   = 50;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    logic [15:0]    i_raw_frame;
    logic           o_out_valid;
    logic           i_out_stall;
    logic           o_mean_valid;
    logic           o_fault;
    logic [C_W-1:0] o_celsius_hundredths;
    logic [F_W-1:0] o_fahrenheit_hundredths;
    logic [C_W-1:0] o_kelvin_hundredths;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [2:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    int pending;
    int errors;
    int send_idle_pct;
    int out_stall_pct;

    thermocouple_moving_average dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_in_valid              (i_in_valid),
        .o_in_stall              (o_in_stall),
        .i_raw_frame             (i_raw_frame),
        .o_out_valid             (o_out_valid),
        .i_out_stall             (i_out_stall),
        .o_mean_valid            (o_mean_valid),
        .o_fault                 (o_fault),
        .o_celsius_hundredths    (o_celsius_hundredths),
        .o_fahrenheit_hundredths (o_fahrenheit_hundredths),
        .o_kelvin_hundredths     (o_kelvin_hundredths),
        .psel                    (psel),
        .penable                 (penable),
        .pwrite                  (pwrite),
        .paddr                   (paddr),
        .pwdata                  (pwdata),
        .prdata                  (prdata),
        .pready                  (pready)
    );

    thermocouple_moving_average_checker checker_i (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_in_valid              (i_in_valid),
        .i_in_stall              (o_in_stall),
        .i_raw_frame             (i_raw_frame),
        .i_out_valid             (o_out_valid),
        .i_out_stall             (i_out_stall),
        .i_mean_valid            (o_mean_valid),
        .i_fault                 (o_fault),
        .i_celsius_hundredths    (o_celsius_hundredths),
        .i_fahrenheit_hundredths (o_fahrenheit_hundredths),
        .i_kelvin_hundredths     (o_kelvin_hundredths),
        .psel                    (psel),
        .penable                 (penable),
        .pwrite                  (pwrite),
        .paddr                   (paddr),
        .pwdata                  (pwdata),
        .pready                  (pready),
        .o_pending               (pending),
        .o_errors                (errors)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    initial begin
        #18_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [15:0] random_frame();
        logic [15:0] f;
        f = 16'($urandom);
        case ($urandom_range(0, 9))
            0: f[15:3] = '1;
            1: f[15:3] = '0;
            default: ;
        endcase
        f[FAULT_BIT] = ($urandom_range(0, 9) == 0);
        return f;
    endfunction

    task automatic send_frame(input logic [15:0] frame);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid  <= 1'b0;
            i_raw_frame <= 16'($urandom);
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_raw_frame <= frame;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_window_length(input logic [LEN_W-1:0] len);
        drain_results();
        repeat (2) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WIN_LEN_ADDR;
        pwdata  <= {27'($urandom), len};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin : stimulus
        logic [LEN_W-1:0] len;
        int               seg_idx;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_raw_frame   = '0;
        i_out_stall   = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        send_idle_pct = 22;
        out_stall_pct = 77;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset length: fault before fill, count extremes
        send_frame(16'h0000);
        send_frame(16'hFFFF);
        send_frame(16'hFFFB);
        send_frame(16'hFFFB);
        send_frame(16'h0007);
        send_frame(16'hFFFB);
        send_frame(16'h0004);

        write_window_length(5'd1);
        send_frame(16'hFFFB);
        send_frame(16'h0000);
        send_frame(16'hFFFC);
        send_frame(16'h0008);

        write_window_length(5'd16);
        for (int i = 0; i < 16; i++) begin
            send_frame({13'h1FFF, 1'b0, 2'($urandom)});
        end
        send_frame(16'h0004);

        seg_idx = 0;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 22; out_stall_pct = 77; end
                1: begin send_idle_pct = 77; out_stall_pct = 22; end
                default: begin send_idle_pct = 0; out_stall_pct = 0; end
            endcase
            for (int s = 0; s < SEGMENTS; s++) begin
                case (seg_idx)
                    0: len = 5'd0;
                    1: len = 5'd31;
                    2: len = 5'd1;
                    3: len = 5'd16;
                    4: len = 5'd17;
                    default: len = 5'($urandom_range(0, 31));
                endcase
                seg_idx++;
                write_window_length(len);
                for (int i = 0; i < SEG_FRAMES; i++) begin
                    send_frame(random_frame());
                    if ($urandom_range(0, 99) == 0) begin
                        drain_results();
                    end
                end
            end
        end

        drain_results();
        repeat (60) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
